>>> rtl/aas_pkg.sv
// alarm annunciator sequence package: field types, codes and state encoding
// no dependencies; used by the interfaces and the core
`timescale 1ns / 1ps
`default_nettype none

package aas_pkg;

   typedef logic [1:0] code_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [2:0] seq_code_type;
   typedef logic [1:0] field_type;

   localparam csr_index_type CSR_NAMUR_MODE      = 2'd0;
   localparam csr_index_type CSR_ACTIVE_POLARITY = 2'd1;
   localparam csr_index_type CSR_AUTO_UNSET      = 2'd2;

   localparam field_type CLS_INVALID    = 2'd0;
   localparam field_type CLS_ACTIVE     = 2'd1;
   localparam field_type CLS_NOT_ACTIVE = 2'd2;
   localparam field_type CLS_FAULT      = 2'd3;

   localparam field_type MIR_NONE   = 2'd0;
   localparam field_type MIR_WRITE0 = 2'd1;
   localparam field_type MIR_WRITE1 = 2'd2;

   localparam field_type RELAY_NONE = 2'd0;
   localparam field_type RELAY_NEW  = 2'd1;
   localparam field_type RELAY_OLD  = 2'd2;

   localparam field_type WT_NONE       = 2'd0;
   localparam field_type WT_ALARM      = 2'd1;
   localparam field_type WT_INDICATION = 2'd2;
   localparam field_type WT_NORMAL     = 2'd3;

   localparam field_type COL_NONE  = 2'd0;
   localparam field_type COL_ALARM = 2'd1;
   localparam field_type COL_NAMUR = 2'd2;

   localparam field_type ACT_NONE  = 2'd0;
   localparam field_type ACT_CLEAR = 2'd1;
   localparam field_type ACT_SET   = 2'd2;

   typedef enum logic [7:0] {
      ST_WAIT_ALARM  = 8'b0000_0001,
      ST_WAIT_AUTO   = 8'b0000_0010,
      ST_WAIT_ACK    = 8'b0000_0100,
      ST_ACKED       = 8'b0000_1000,
      ST_RESET_WAIT  = 8'b0001_0000,
      ST_ACK_NORMAL  = 8'b0010_0000,
      ST_FAULT_ENTRY = 8'b0100_0000,
      ST_FAULT_WAIT  = 8'b1000_0000
   } seq_state_type;

   function automatic seq_code_type encode_state(input seq_state_type st);
      seq_code_type code;
      case (st)
         ST_WAIT_ALARM:  code = 3'd0;
         ST_WAIT_AUTO:   code = 3'd1;
         ST_WAIT_ACK:    code = 3'd2;
         ST_ACKED:       code = 3'd3;
         ST_RESET_WAIT:  code = 3'd4;
         ST_ACK_NORMAL:  code = 3'd5;
         ST_FAULT_ENTRY: code = 3'd6;
         ST_FAULT_WAIT:  code = 3'd7;
         default:        code = 3'd0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> rtl/aas_req_if.sv
// input channel interface: valid/ready handshake and one scan tick item
// depends on aas_pkg
`timescale 1ns / 1ps
`default_nettype none

interface aas_req_if;
   logic               valid;
   logic               ready;
   aas_pkg::code_type  line_code;
   logic               line_invalid;
   logic               reset_cmd;
   logic               ack_cmd;

   modport source(output valid, line_code, line_invalid, reset_cmd, ack_cmd, input ready);
   modport sink(input valid, line_code, line_invalid, reset_cmd, ack_cmd, output ready);
endinterface

`default_nettype wire

>>> rtl/aas_rsp_if.sv
// result channel interface: valid/ready handshake and one result item
// depends on aas_pkg
`timescale 1ns / 1ps
`default_nettype none

interface aas_rsp_if;
   logic                  valid;
   logic                  ready;
   aas_pkg::seq_code_type seq_state;
   aas_pkg::field_type    signal_class;
   aas_pkg::field_type    mirror_write;
   aas_pkg::field_type    relay_write;
   aas_pkg::field_type    window_type_write;
   aas_pkg::field_type    window_color_write;
   aas_pkg::field_type    activity_write;

   modport source(output valid, seq_state, signal_class, mirror_write, relay_write,
                  window_type_write, window_color_write, activity_write, input ready);
   modport sink(input valid, seq_state, signal_class, mirror_write, relay_write,
                window_type_write, window_color_write, activity_write, output ready);
endinterface

`default_nettype wire

>>> rtl/alarm_annunciator_sequence_core.sv
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless the result side stalls; the sequence state register
// updates in the same cycle that an item moves from input register into result register
// reset: sequence returns to wait for alarm, all configuration bits clear, both stages empty
// depends on aas_pkg, aas_req_if and aas_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module alarm_annunciator_sequence_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   aas_req_if.sink                     req_port,
   aas_rsp_if.source                   rsp_port,
   input  wire logic                   csr_write_enable,
   input  wire aas_pkg::csr_index_type csr_index,
   input  wire logic                   csr_write_data
);

   // configuration
   logic namur_mode_ff, active_polarity_ff, auto_unset_ff;

   // input stage
   logic              in_valid_ff, in_valid_in;
   aas_pkg::code_type code_ff;
   logic              invalid_ff, rst_ff, ack_ff;

   // sequence state
   aas_pkg::seq_state_type state_ff, state_in;

   // result stage
   logic                  out_valid_ff, out_valid_in;
   aas_pkg::seq_code_type seq_state_ff;
   aas_pkg::field_type    cls_ff, mirror_ff, relay_ff, wt_ff, col_ff, act_ff;

   // decode
   aas_pkg::field_type cls_in, mirror_in, relay_in, wt_in, col_in, act_in;
   logic               low_level;

   logic accept, out_free, move;

   assign out_free = !out_valid_ff || rsp_port.ready;
   assign move     = in_valid_ff && out_free;
   assign req_port.ready = !reset && (!in_valid_ff || out_free);
   assign accept   = req_port.valid && req_port.ready;

   assign in_valid_in  = accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         namur_mode_ff      <= 1'b0;
         active_polarity_ff <= 1'b0;
         auto_unset_ff      <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            aas_pkg::CSR_NAMUR_MODE:      namur_mode_ff      <= csr_write_data;
            aas_pkg::CSR_ACTIVE_POLARITY: active_polarity_ff <= csr_write_data;
            aas_pkg::CSR_AUTO_UNSET:      auto_unset_ff      <= csr_write_data;
            default: ;
         endcase
      end
   end

   // line classification
   always_comb begin
      low_level = namur_mode_ff ? (code_ff == 2'd0) : (code_ff[0] ^ code_ff[1]);
      if (invalid_ff) begin
         cls_in    = aas_pkg::CLS_INVALID;
         mirror_in = aas_pkg::MIR_NONE;
      end else if (namur_mode_ff && code_ff[1]) begin
         cls_in    = aas_pkg::CLS_FAULT;
         mirror_in = aas_pkg::MIR_WRITE0;
      end else begin
         mirror_in = low_level ? aas_pkg::MIR_WRITE0 : aas_pkg::MIR_WRITE1;
         cls_in    = (low_level == active_polarity_ff) ? aas_pkg::CLS_ACTIVE
                                                       : aas_pkg::CLS_NOT_ACTIVE;
      end
   end

   // annunciator sequence
   always_comb begin
      state_in = state_ff;
      relay_in = aas_pkg::RELAY_NONE;
      wt_in    = aas_pkg::WT_NONE;
      col_in   = aas_pkg::COL_NONE;
      act_in   = aas_pkg::ACT_NONE;
      case (state_ff)
         aas_pkg::ST_WAIT_ALARM: begin
            if (cls_in == aas_pkg::CLS_FAULT) begin
               state_in = aas_pkg::ST_FAULT_ENTRY;
            end else if (cls_in == aas_pkg::CLS_ACTIVE) begin
               relay_in = aas_pkg::RELAY_NEW;
               wt_in    = aas_pkg::WT_ALARM;
               col_in   = aas_pkg::COL_ALARM;
               act_in   = aas_pkg::ACT_SET;
               state_in = auto_unset_ff ? aas_pkg::ST_WAIT_AUTO : aas_pkg::ST_WAIT_ACK;
            end
         end
         aas_pkg::ST_WAIT_AUTO, aas_pkg::ST_WAIT_ACK: begin
            if (state_ff == aas_pkg::ST_WAIT_AUTO && cls_in == aas_pkg::CLS_NOT_ACTIVE) begin
               wt_in    = aas_pkg::WT_NORMAL;
               act_in   = aas_pkg::ACT_CLEAR;
               state_in = aas_pkg::ST_WAIT_ALARM;
            end else begin
               if (cls_in == aas_pkg::CLS_ACTIVE) begin
                  relay_in = aas_pkg::RELAY_OLD;
               end
               if (rst_ff) begin
                  wt_in    = aas_pkg::WT_INDICATION;
                  state_in = aas_pkg::ST_RESET_WAIT;
               end else if (ack_ff) begin
                  wt_in    = aas_pkg::WT_INDICATION;
                  state_in = aas_pkg::ST_ACKED;
               end
            end
         end
         aas_pkg::ST_ACKED: begin
            if (rst_ff) begin
               state_in = aas_pkg::ST_RESET_WAIT;
            end else if (cls_in == aas_pkg::CLS_NOT_ACTIVE) begin
               state_in = aas_pkg::ST_ACK_NORMAL;
            end else if (cls_in == aas_pkg::CLS_ACTIVE) begin
               relay_in = aas_pkg::RELAY_OLD;
            end
         end
         aas_pkg::ST_RESET_WAIT: begin
            if (cls_in == aas_pkg::CLS_NOT_ACTIVE) begin
               wt_in    = aas_pkg::WT_NORMAL;
               act_in   = aas_pkg::ACT_CLEAR;
               state_in = aas_pkg::ST_WAIT_ALARM;
            end else if (cls_in == aas_pkg::CLS_ACTIVE) begin
               relay_in = aas_pkg::RELAY_OLD;
            end
         end
         aas_pkg::ST_ACK_NORMAL: begin
            if (cls_in == aas_pkg::CLS_ACTIVE) begin
               relay_in = aas_pkg::RELAY_OLD;
            end else if (cls_in == aas_pkg::CLS_FAULT) begin
               state_in = aas_pkg::ST_FAULT_ENTRY;
            end
            if (rst_ff) begin
               wt_in    = aas_pkg::WT_NORMAL;
               act_in   = aas_pkg::ACT_CLEAR;
               state_in = aas_pkg::ST_WAIT_ALARM;
            end
         end
         aas_pkg::ST_FAULT_ENTRY: begin
            wt_in    = aas_pkg::WT_INDICATION;
            col_in   = aas_pkg::COL_NAMUR;
            act_in   = aas_pkg::ACT_SET;
            state_in = aas_pkg::ST_FAULT_WAIT;
         end
         aas_pkg::ST_FAULT_WAIT: begin
            if (cls_in != aas_pkg::CLS_FAULT) begin
               wt_in    = aas_pkg::WT_NORMAL;
               act_in   = aas_pkg::ACT_CLEAR;
               state_in = aas_pkg::ST_WAIT_ALARM;
            end
         end
         default: begin
            state_in = aas_pkg::ST_WAIT_ALARM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= aas_pkg::ST_WAIT_ALARM;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         code_ff    <= req_port.line_code;
         invalid_ff <= req_port.line_invalid;
         rst_ff     <= req_port.reset_cmd;
         ack_ff     <= req_port.ack_cmd;
      end
      if (move) begin
         seq_state_ff <= aas_pkg::encode_state(state_in);
         cls_ff       <= cls_in;
         mirror_ff    <= mirror_in;
         relay_ff     <= relay_in;
         wt_ff        <= wt_in;
         col_ff       <= col_in;
         act_ff       <= act_in;
      end
   end

   assign rsp_port.valid              = out_valid_ff;
   assign rsp_port.seq_state          = seq_state_ff;
   assign rsp_port.signal_class       = cls_ff;
   assign rsp_port.mirror_write       = mirror_ff;
   assign rsp_port.relay_write        = relay_ff;
   assign rsp_port.window_type_write  = wt_ff;
   assign rsp_port.window_color_write = col_ff;
   assign rsp_port.activity_write     = act_ff;

   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequence state register not one-hot");

   a_fault_entry_passes : assert property (@(posedge clock) disable iff (reset)
      move && state_ff == aas_pkg::ST_FAULT_ENTRY |=> state_ff == aas_pkg::ST_FAULT_WAIT)
      else $error("fault entry not followed by fault wait");

   a_ready_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> in_valid_ff && out_valid_ff && !rsp_port.ready)
      else $error("input held off with room in the pipeline");

   a_new_alarm_marks : assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.relay_write == aas_pkg::RELAY_NEW
         |-> rsp_port.activity_write == aas_pkg::ACT_SET
             && rsp_port.seq_state != aas_pkg::encode_state(aas_pkg::ST_WAIT_ALARM))
      else $error("new violation without activity set or with idle state");

   a_invalid_no_mirror : assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && rsp_port.signal_class == aas_pkg::CLS_INVALID
         |-> rsp_port.mirror_write == aas_pkg::MIR_NONE)
      else $error("mirror written on an invalid reading");

endmodule

`default_nettype wire

>>> sim/alarm_annunciator_sequence_checker.sv
// scoreboard for the alarm annunciator sequence core: watches both channels and the csr port,
// predicts each result item from its own copy of the sequence and settings, and counts mismatches
// depends on aas_pkg, aas_req_if and aas_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module alarm_annunciator_sequence_checker
   import aas_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   aas_req_if                 req_mon,
   aas_rsp_if                 rsp_mon,
   input  wire logic          csr_write_enable,
   input  wire csr_index_type csr_index,
   input  wire logic          csr_write_data,
   output int                 fail_count,
   output int                 pending_count
);

   typedef enum logic [2:0] {
      SEQ_IDLE        = 3'd0,
      SEQ_WAIT_AUTO   = 3'd1,
      SEQ_WAIT_ACK    = 3'd2,
      SEQ_ACKED       = 3'd3,
      SEQ_RESET_WAIT  = 3'd4,
      SEQ_ACK_NORMAL  = 3'd5,
      SEQ_FAULT_ENTRY = 3'd6,
      SEQ_FAULT_WAIT  = 3'd7
   } window_seq_e;

   typedef struct packed {
      seq_code_type seq_state;
      field_type    signal_class;
      field_type    mirror_write;
      field_type    relay_write;
      field_type    window_type_write;
      field_type    window_color_write;
      field_type    activity_write;
   } window_update_t;

   logic           namur_on;
   logic           alarm_on_low;
   logic           auto_clear_on;
   window_seq_e    window_seq;
   window_update_t window_updates_q[$];
   int             mismatches;

   initial begin
      mismatches = 0;
   end

   function automatic window_update_t next_window(input code_type code, input logic bad_read,
                                                  input logic rst, input logic ack);
      window_update_t u;
      window_seq_e    nxt;
      logic           low;
      u   = '0;
      nxt = window_seq;
      u.signal_class = CLS_INVALID;
      if (!bad_read) begin
         // namur: wire break and short both have the upper bit set
         if (namur_on && code[1]) begin
            u.signal_class = CLS_FAULT;
            u.mirror_write = MIR_WRITE0;
         end else begin
            // namur: only off is low; plain: on and wire break are low
            low = namur_on ? !code[0] : (code[1] ^ code[0]);
            u.mirror_write = low ? MIR_WRITE0 : MIR_WRITE1;
            u.signal_class = (low == alarm_on_low) ? CLS_ACTIVE : CLS_NOT_ACTIVE;
         end
      end
      case (window_seq)
         SEQ_IDLE: begin
            if (u.signal_class == CLS_FAULT) begin
               nxt = SEQ_FAULT_ENTRY;
            end else if (u.signal_class == CLS_ACTIVE) begin
               u.relay_write        = RELAY_NEW;
               u.window_type_write  = WT_ALARM;
               u.window_color_write = COL_ALARM;
               u.activity_write     = ACT_SET;
               nxt = auto_clear_on ? SEQ_WAIT_AUTO : SEQ_WAIT_ACK;
            end
         end
         SEQ_WAIT_AUTO, SEQ_WAIT_ACK: begin
            if (window_seq == SEQ_WAIT_AUTO && u.signal_class == CLS_NOT_ACTIVE) begin
               // auto-clear wins over any command
               u.window_type_write = WT_NORMAL;
               u.activity_write    = ACT_CLEAR;
               nxt = SEQ_IDLE;
            end else begin
               if (u.signal_class == CLS_ACTIVE) u.relay_write = RELAY_OLD;
               if (rst) begin
                  u.window_type_write = WT_INDICATION;
                  nxt = SEQ_RESET_WAIT;
               end else if (ack) begin
                  u.window_type_write = WT_INDICATION;
                  nxt = SEQ_ACKED;
               end
            end
         end
         SEQ_ACKED: begin
            if (rst) nxt = SEQ_RESET_WAIT;
            else if (u.signal_class == CLS_NOT_ACTIVE) nxt = SEQ_ACK_NORMAL;
            else if (u.signal_class == CLS_ACTIVE) u.relay_write = RELAY_OLD;
         end
         SEQ_RESET_WAIT: begin
            if (u.signal_class == CLS_NOT_ACTIVE) begin
               u.window_type_write = WT_NORMAL;
               u.activity_write    = ACT_CLEAR;
               nxt = SEQ_IDLE;
            end else if (u.signal_class == CLS_ACTIVE) begin
               u.relay_write = RELAY_OLD;
            end
         end
         SEQ_ACK_NORMAL: begin
            if (u.signal_class == CLS_ACTIVE) u.relay_write = RELAY_OLD;
            else if (u.signal_class == CLS_FAULT) nxt = SEQ_FAULT_ENTRY;
            if (rst) begin
               u.window_type_write = WT_NORMAL;
               u.activity_write    = ACT_CLEAR;
               nxt = SEQ_IDLE;
            end
         end
         SEQ_FAULT_ENTRY: begin
            u.window_type_write  = WT_INDICATION;
            u.window_color_write = COL_NAMUR;
            u.activity_write     = ACT_SET;
            nxt = SEQ_FAULT_WAIT;
         end
         default: begin
            // an invalid reading counts as recovery too
            if (u.signal_class != CLS_FAULT) begin
               u.window_type_write = WT_NORMAL;
               u.activity_write    = ACT_CLEAR;
               nxt = SEQ_IDLE;
            end
         end
      endcase
      u.seq_state = nxt;
      return u;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      window_update_t want;
      if (reset) begin
         namur_on      = 1'b0;
         alarm_on_low  = 1'b0;
         auto_clear_on = 1'b0;
         window_seq    = SEQ_IDLE;
         window_updates_q.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_NAMUR_MODE:      namur_on      = csr_write_data;
               CSR_ACTIVE_POLARITY: alarm_on_low  = csr_write_data;
               CSR_AUTO_UNSET:      auto_clear_on = csr_write_data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            want = next_window(req_mon.line_code, req_mon.line_invalid,
                               req_mon.reset_cmd, req_mon.ack_cmd);
            window_seq = window_seq_e'(want.seq_state);
            window_updates_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (window_updates_q.size() == 0) begin
               $display("%0t: result item with none outstanding, expected nothing actual %0d",
                        $time, rsp_mon.seq_state);
               mismatches++;
            end else begin
               want = window_updates_q.pop_front();
               check_field("seq_state", want.seq_state, rsp_mon.seq_state);
               check_field("signal_class", want.signal_class, rsp_mon.signal_class);
               check_field("mirror_write", want.mirror_write, rsp_mon.mirror_write);
               check_field("relay_write", want.relay_write, rsp_mon.relay_write);
               check_field("window_type_write", want.window_type_write,
                           rsp_mon.window_type_write);
               check_field("window_color_write", want.window_color_write,
                           rsp_mon.window_color_write);
               check_field("activity_write", want.activity_write, rsp_mon.activity_write);
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= window_updates_q.size();
   end

endmodule

`default_nettype wire

>>> sim/alarm_annunciator_sequence_core_test.sv
// top of the alarm annunciator sequence testbench: clock, reset, csr settings, scan tick items
// in bursts, result stalls, watchdog and verdict
// depends on aas_pkg, aas_req_if, aas_rsp_if, the core and alarm_annunciator_sequence_checker
`timescale 1ns / 1ps
`default_nettype none

module alarm_annunciator_sequence_core_test;
   import aas_pkg::*;

   localparam code_type      LINE_OFF   = 2'd0;
   localparam code_type      LINE_ON    = 2'd1;
   localparam code_type      LINE_BREAK = 2'd2;
   localparam code_type      LINE_SHORT = 2'd3;
   localparam csr_index_type CSR_SPARE  = 2'd3;
   localparam int            QUIET_LIMIT    = 4000;
   localparam int            ITEMS_PER_SET  = 190;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SOME,
      STALL_HEAVY
   } stall_e;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_write_enable;
   csr_index_type csr_index;
   logic          csr_write_data;
   int            fail_count;
   int            pending_count;
   int            burst_left = 0;
   int            quiet_cycles = 0;
   stall_e        stall_mode = STALL_NONE;
   int            stall_left = 0;

   aas_req_if req_ch ();
   aas_rsp_if rsp_ch ();

   alarm_annunciator_sequence_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_ch),
      .rsp_port         (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   alarm_annunciator_sequence_checker scoreboard (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #10 clock = ~clock;

   // result side stalls in modes of random length
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_e'($urandom_range(0, 2));
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE: rsp_ch.ready <= 1'b1;
         STALL_SOME: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default:    rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_tick(input code_type code, input logic bad_read, input logic rst,
                            input logic ack);
      int gap;
      req_ch.valid        <= 1'b1;
      req_ch.line_code    <= code;
      req_ch.line_invalid <= bad_read;
      req_ch.reset_cmd    <= rst;
      req_ch.ack_cmd      <= ack;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic namur, input logic low_alarm, input logic auto_clr);
      req_ch.valid     <= 1'b0;
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_NAMUR_MODE;
      csr_write_data   <= namur;
      @(posedge clock);
      csr_index        <= CSR_ACTIVE_POLARITY;
      csr_write_data   <= low_alarm;
      @(posedge clock);
      csr_index        <= CSR_AUTO_UNSET;
      csr_write_data   <= auto_clr;
      @(posedge clock);
      // unused index, must change nothing
      csr_index        <= CSR_SPARE;
      csr_write_data   <= ~auto_clr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_ticks(input int count);
      code_type held;
      held = code_type'($urandom_range(0, 3));
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_tick(code_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            // line held steady for a while, commands now and then
            if ($urandom_range(0, 3) == 0) held = code_type'($urandom_range(0, 3));
            send_tick(held, $urandom_range(0, 15) == 0, $urandom_range(0, 7) == 0,
                      $urandom_range(0, 4) == 0);
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_NAMUR_MODE;
      csr_write_data      <= 1'b0;
      req_ch.valid        <= 1'b0;
      req_ch.line_code    <= LINE_OFF;
      req_ch.line_invalid <= 1'b0;
      req_ch.reset_cmd    <= 1'b0;
      req_ch.ack_cmd      <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // plain input, alarm on high, latching
      write_settings(1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_SHORT, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b1);
      send_tick(LINE_BREAK, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b1, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b1, 1'b1, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b1, 1'b0, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b1, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);

      // namur input, alarm on low, auto-clear
      write_settings(1'b1, 1'b1, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b1);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_BREAK, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_SHORT, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_SHORT, 1'b1, 1'b0, 1'b0);
      send_tick(LINE_BREAK, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b1);
      send_tick(LINE_OFF, 1'b0, 1'b0, 1'b1);
      send_tick(LINE_ON, 1'b0, 1'b0, 1'b0);
      send_tick(LINE_SHORT, 1'b0, 1'b1, 1'b0);

      for (int setting = 0; setting < 8; setting++) begin
         write_settings(setting[0], setting[1], setting[2]);
         random_ticks(ITEMS_PER_SET);
      end

      req_ch.valid <= 1'b0;
      wait_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/aas_pkg.sv
rtl/aas_req_if.sv
rtl/aas_rsp_if.sv
rtl/alarm_annunciator_sequence_core.sv
sim/alarm_annunciator_sequence_checker.sv
sim/alarm_annunciator_sequence_core_test.sv
